>>> hdl/lqr_pkg.sv
package lqr_pkg;

    // Field widths fixed by the interface.
    localparam int WORD_W = 32;
    localparam int CAP_W  = 5;
    localparam int OP_W   = 2;
    localparam int STS_W  = 2;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request codes.
    typedef enum logic [OP_W-1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ     = 2'd1,
        OP_FRONT   = 2'd2,
        OP_REPLACE = 2'd3
    } op_t;

    // Result status codes.
    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_OVER  = 2'd1;
    localparam logic [STS_W-1:0] ST_UNDER = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic enq;         // enqueue the input word, or report overflow
        logic under;       // report underflow
        logic under_word;  // underflow result carries -1 rather than 0
        logic rd_head;     // issue a read of the head slot
        logic deq_done;    // finish a dequeue from the read data
        logic front_done;  // finish a front read from the read data
        logic scan_start;  // latch match words and start the replace walk
        logic scan_rd;     // issue the next read of the replace walk
        logic scan_fin;    // retire the last write and settle the indices
    } lqr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic rd_at_tail;
    } lqr_sts_t;

endpackage

>>> hdl/linear_queue_with_replace_core.sv
// Enqueue and underflow results are registered straight from the request beat;
// dequeue and front pass through the registered read of the slot memory first.
// Replace walks the stored words from head to tail, one memory read per cycle,
// then retires the last write. No new request is taken while one is at work.
// Reset zeroes head and tail, marks the queue empty and sets capacity to 16; the
// slot memory is not cleared and needs no clearing pass.
module linear_queue_with_replace_core
    import lqr_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          op,
    input  logic signed [WORD_W-1:0] value,
    input  logic signed [WORD_W-1:0] new_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] data,
    output logic [STS_W-1:0]         status
);

    lqr_cmd_t cmd;
    lqr_sts_t sts;

    // Sequencer for the four request types.
    lqr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Slot memory, indices and result register.
    lqr_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_value     (value),
        .in_new_value (new_value),
        .cmd          (cmd),
        .sts          (sts),
        .out_data     (data),
        .out_status   (status)
    );

endmodule

>>> hdl/lqr_ctrl.sv
module lqr_ctrl
    import lqr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     in_op,
    output logic                out_valid,
    input  logic                out_ready,
    input  lqr_sts_t            sts,
    output lqr_cmd_t            cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   is_deq_reg;
    logic   is_deq_next;
    logic   accept;

    // A new request is taken only when idle and the result register is free
    // or being emptied in this cycle.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        is_deq_next    = is_deq_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(in_op) == OP_ENQ)
                    begin
                        cmd.enq        = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else if (sts.empty)
                    begin
                        cmd.under      = 1'b1;
                        cmd.under_word = (op_t'(in_op) != OP_REPLACE);
                        out_valid_next = 1'b1;
                    end
                    else if (op_t'(in_op) == OP_REPLACE)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        is_deq_next = (op_t'(in_op) == OP_DEQ);
                        state_next  = S_RD_WAIT;
                    end
                end
            end
            S_RD_WAIT:
            begin
                cmd.deq_done   = is_deq_reg;
                cmd.front_done = !is_deq_reg;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.rd_at_tail)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.scan_fin   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            is_deq_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            is_deq_reg    <= is_deq_next;
        end
    end

endmodule

>>> hdl/lqr_dpath.sv
module lqr_dpath
    import lqr_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data,
    input  logic signed [WORD_W-1:0] in_value,
    input  logic signed [WORD_W-1:0] in_new_value,
    input  lqr_cmd_t                 cmd,
    output lqr_sts_t                 sts,
    output logic signed [WORD_W-1:0] out_data,
    output logic [STS_W-1:0]         out_status
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Slot storage: one write and one registered read per cycle.
    logic [WORD_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0]   capacity_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   tail_reg;
    logic [IDX_W-1:0]   tail_next;
    logic               empty_reg;
    logic               empty_next;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic [IDX_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pend_reg;
    logic [WORD_W-1:0]  match_reg;
    logic [WORD_W-1:0]  subst_reg;
    logic [WORD_W-1:0]  rdata_reg;
    logic [WORD_W-1:0]  data_reg;
    logic [WORD_W-1:0]  data_next;
    logic [STS_W-1:0]   status_reg;
    logic [STS_W-1:0]   status_next;

    logic [CNT_W-1:0]   cap_use;
    logic               full;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               scan_wr;
    logic [WORD_W-1:0]  scan_word;
    logic [CNT_W-1:0]   count_fin;

    // Usable size saturates at the storage depth.
    always_comb
    begin
        if (32'(capacity_reg) > DEPTH)
        begin
            cap_use = CNT_W'(DEPTH);
        end
        else
        begin
            cap_use = CNT_W'(capacity_reg);
        end
    end

    // The queue is full once the tail sits on the last usable slot.
    assign full = empty_reg ? (cap_use == '0)
                            : ((CNT_W'(tail_reg) + CNT_W'(1)) >= cap_use);

    assign sts.empty      = empty_reg;
    assign sts.rd_at_tail = (rd_ptr_reg == tail_reg);

    // Replace walk: substitute matches and compact towards slot 0.
    assign scan_word = (rdata_reg == match_reg) ? subst_reg : rdata_reg;
    assign scan_wr   = pend_reg && (count_reg < cap_use);
    assign count_fin = count_reg + CNT_W'(scan_wr);

    // Memory port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = scan_word;
        if (cmd.enq && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = empty_reg ? '0 : (tail_reg + IDX_W'(1));
            wr_data = in_value;
        end
        else if (scan_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
        end
    end

    assign rd_en   = cmd.rd_head || cmd.scan_rd;
    assign rd_addr = cmd.rd_head ? head_reg : rd_ptr_reg;

    // Index, walk and result updates.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        data_next   = data_reg;
        status_next = status_reg;

        if (cmd.enq)
        begin
            data_next = '0;
            if (full)
            begin
                status_next = ST_OVER;
            end
            else
            begin
                status_next = ST_OK;
                empty_next  = 1'b0;
                if (empty_reg)
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else
                begin
                    tail_next = tail_reg + IDX_W'(1);
                end
            end
        end

        if (cmd.under)
        begin
            status_next = ST_UNDER;
            data_next   = cmd.under_word ? '1 : '0;
        end

        if (cmd.deq_done || cmd.front_done)
        begin
            status_next = ST_OK;
            data_next   = rdata_reg;
        end

        if (cmd.deq_done)
        begin
            if (head_reg >= tail_reg)
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b1;
            end
            else
            begin
                head_next = head_reg + IDX_W'(1);
            end
        end

        if (cmd.scan_start)
        begin
            rd_ptr_next = head_reg;
            count_next  = '0;
        end

        if (cmd.scan_rd)
        begin
            rd_ptr_next = rd_ptr_reg + IDX_W'(1);
        end

        if (scan_wr)
        begin
            count_next = count_fin;
        end

        if (cmd.scan_fin)
        begin
            status_next = ST_OK;
            data_next   = '0;
            head_next   = '0;
            if (count_fin == '0)
            begin
                tail_next  = '0;
                empty_next = 1'b1;
            end
            else
            begin
                tail_next  = IDX_W'(count_fin - CNT_W'(1));
                empty_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            pend_reg  <= cmd.scan_rd;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        count_reg  <= count_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        if (cmd.scan_start)
        begin
            match_reg <= in_value;
            subst_reg <= in_new_value;
        end
    end

    // Slot memory.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_data   = data_reg;
    assign out_status = status_reg;

endmodule
